// ----- sv/lbsph_pkg.sv -----
package lbsph_pkg;

   localparam int NUM_BANDS_DEF = 32;
   localparam int LOG_TABLE_DEPTH_DEF = 256;
   localparam int OPQ_DEPTH = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 16;

   localparam logic [18:0] DB_K = 19'd394566;
   localparam logic signed [17:0] DB_ZERO_MAG = -18'sd51200;
   localparam logic [15:0] LEVEL_ONE = 16'd32768;
   localparam logic [15:0] FRAME_COUNT_MAX = 16'hFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE_MODE     = 3'd0,
      CSR_AGGREGATE_MODE = 3'd1,
      CSR_NOISE_FLOOR    = 3'd2,
      CSR_LINEAR_GAIN    = 3'd3,
      CSR_DB_FLOOR       = 3'd4,
      CSR_DB_CEILING     = 3'd5
   } csr_index_type;

   typedef enum logic {
      CMD_BIN  = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        cmd;
      logic [4:0]  band;
      logic [15:0] mag_left;
      logic [15:0] mag_right;
      logic        last_of_band;
      logic        last_of_frame;
   } req_type;

   typedef struct packed {
      logic [15:0] level_left;
      logic [15:0] level_right;
      logic        have_data;
   } rsp_type;

   typedef struct packed {
      cmd_type     kind;
      logic [4:0]  band;
      logic [15:0] max_left;
      logic [15:0] max_right;
      logic        merge;
      logic        frame_end;
   } op_type;

   typedef struct packed {
      logic               scale_mode;
      logic               aggregate_mode;
      logic [15:0]        noise_floor;
      logic [15:0]        linear_gain;
      logic signed [15:0] db_floor;
      logic signed [15:0] db_ceiling;
   } cfg_type;

   function automatic logic [15:0] log_squarings(input logic [63:0] v0);
      logic [63:0] v;
      logic [15:0] r;
      v = v0;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         v = (v * v) >> 30;
         r = {r[14:0], 1'b0};
         if (v >= 64'h8000_0000) begin
            r[0] = 1'b1;
            v = v >> 1;
         end
      end
      return r;
   endfunction

endpackage

// ----- sv/lbsph_fifo.sv -----
module lbsph_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lbsph_pkg::op_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output lbsph_pkg::op_type pop_data
);

   localparam int AW = $clog2(lbsph_pkg::OPQ_DEPTH);

   lbsph_pkg::op_type mem_ff [lbsph_pkg::OPQ_DEPTH];
   logic [AW-1:0] wr_ff;
   logic [AW-1:0] rd_ff;
   logic [AW:0]   count_ff;
   logic          do_push;
   logic          do_pop;

   assign full     = count_ff == (AW+1)'(lbsph_pkg::OPQ_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- sv/lbsph_front.sv -----
module lbsph_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  lbsph_pkg::req_type req_data,
   output logic               req_full,
   output logic               q_push,
   output lbsph_pkg::op_type  q_data,
   input  logic               q_full
);

   logic [15:0] max_left_ff;
   logic [15:0] max_right_ff;
   logic [15:0] max_left_in;
   logic [15:0] max_right_in;
   logic        accept;
   logic        is_read;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign is_read  = req_data.cmd == lbsph_pkg::CMD_READ;

   always_comb begin
      max_left_in  = (req_data.mag_left > max_left_ff) ? req_data.mag_left : max_left_ff;
      max_right_in = (req_data.mag_right > max_right_ff) ? req_data.mag_right : max_right_ff;
      q_data.kind      = is_read ? lbsph_pkg::CMD_READ : lbsph_pkg::CMD_BIN;
      q_data.band      = req_data.band;
      q_data.max_left  = max_left_in;
      q_data.max_right = max_right_in;
      q_data.merge     = req_data.last_of_band;
      q_data.frame_end = req_data.last_of_frame;
      q_push = accept && (is_read || req_data.last_of_band || req_data.last_of_frame);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_left_ff  <= '0;
         max_right_ff <= '0;
      end else if (accept && !is_read) begin
         if (req_data.last_of_band) begin
            max_left_ff  <= '0;
            max_right_ff <= '0;
         end else begin
            max_left_ff  <= max_left_in;
            max_right_ff <= max_right_in;
         end
      end
   end

endmodule

// ----- sv/lbsph_div.sv -----
module lbsph_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lbsph_pkg::DIV_NUM_W-1:0]  num,
   input  logic [lbsph_pkg::DIV_DEN_W-1:0]  den,
   output logic                             busy,
   output logic                             done,
   output logic [lbsph_pkg::DIV_NUM_W-1:0]  quo
);

   localparam int NW = lbsph_pkg::DIV_NUM_W;
   localparam int DW = lbsph_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] count_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW:0]   rem_sh;
   logic [DW:0]   rem_diff;
   logic          bit_q;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[NW-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      bit_q    = rem_sh >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff  <= 1'b1;
            quo_ff   <= num;
            rem_ff   <= '0;
            den_ff   <= den;
            count_ff <= CW'(NW);
         end else if (busy_ff) begin
            quo_ff   <= {quo_ff[NW-2:0], bit_q};
            rem_ff   <= bit_q ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
            count_ff <= count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- sv/lbsph_back.sv -----
module lbsph_back #(
   parameter int NUM_BANDS       = lbsph_pkg::NUM_BANDS_DEF,
   parameter int LOG_TABLE_DEPTH = lbsph_pkg::LOG_TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  lbsph_pkg::cfg_type cfg,
   input  logic               cfg_clear,
   input  logic               q_empty,
   output logic               q_pop,
   input  lbsph_pkg::op_type  q_data,
   output logic               out_valid,
   output lbsph_pkg::rsp_type out_data,
   input  logic               out_pop
);

   localparam int BAND_AW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int TAB_AW    = $clog2(LOG_TABLE_DEPTH);
   localparam int DEPTH_W   = $clog2(LOG_TABLE_DEPTH + 1);
   localparam int IDX_PW    = 15 + DEPTH_W;
   localparam int LAST_BAND = ((NUM_BANDS < 32) ? NUM_BANDS : 32) - 1;

   typedef enum logic [4:0] {
      S_IDLE, S_FETCH, S_SUB, S_LINMUL, S_NORM, S_IDX, S_TAB, S_LOGMUL, S_DB,
      S_DIVWAIT, S_CHAN, S_MERGE, S_FRAME, S_RDDIV, S_RDWAIT, S_RDNEXT, S_OUT
   } state_type;

   logic [15:0] log_rom [LOG_TABLE_DEPTH];

   for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_rom
      localparam logic [63:0] V0 =
         ((64'(LOG_TABLE_DEPTH) + 64'(g)) << 30) / LOG_TABLE_DEPTH;
      assign log_rom[g] = lbsph_pkg::log_squarings(V0);
   end

   state_type          state_ff;
   lbsph_pkg::op_type  op_ff;
   logic [63:0]        slot_ff;
   logic               slot_valid_ff;
   logic               ch_ff;
   logic [15:0]        m_ff;
   logic [3:0]         e_ff;
   logic [15:0]        x_ff;
   logic [TAB_AW-1:0]  idx_ff;
   logic [15:0]        tab_ff;
   logic [39:0]        prod_ff;
   logic               neg_ff;
   logic signed [31:0] lvl_ff [2];
   logic [15:0]        fc_ff;
   logic [NUM_BANDS-1:0] valid_ff;
   lbsph_pkg::rsp_type pend_ff;
   logic               out_valid_ff;
   lbsph_pkg::rsp_type out_ff;
   logic [63:0]        store_mem [NUM_BANDS];

   logic [BAND_AW-1:0] q_idx;
   logic [BAND_AW-1:0] op_idx;
   logic               in_range;
   logic signed [31:0] slot_left;
   logic signed [31:0] slot_right;
   logic signed [31:0] slot_cur;
   logic [15:0]        rm;
   logic [15:0]        m_in;
   logic [31:0]        lin_prod;
   logic [3:0]         e_in;
   logic [15:0]        x_in;
   logic [IDX_PW-1:0]  idx_prod;
   logic [20:0]        lneg;
   logic [39:0]        db_sum;
   logic [15:0]        db_q;
   logic signed [17:0] db;
   logic signed [18:0] diff;
   logic signed [16:0] range;
   logic [18:0]        diff_mag;
   logic [16:0]        range_mag;
   logic               rd_divide;
   logic               div_start;
   logic               div_busy;
   logic               div_done;
   logic [lbsph_pkg::DIV_NUM_W-1:0] div_num;
   logic [lbsph_pkg::DIV_DEN_W-1:0] div_den;
   logic [lbsph_pkg::DIV_NUM_W-1:0] div_quo;
   logic signed [31:0] merge_left;
   logic signed [31:0] merge_right;
   logic               out_free;

   function automatic logic signed [31:0] merge_val(input logic signed [31:0] slot,
                                                    input logic signed [31:0] lv,
                                                    input logic first,
                                                    input logic avg);
      logic signed [32:0] sum;
      logic signed [31:0] r;
      sum = 33'(slot) + 33'(lv);
      if (first) begin
         r = lv;
      end else if (avg) begin
         if (sum > 33'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
         end else if (sum < -33'sh0_8000_0000) begin
            r = -32'sh8000_0000;
         end else begin
            r = sum[31:0];
         end
      end else begin
         r = (lv > slot) ? lv : slot;
      end
      return r;
   endfunction

   function automatic logic [15:0] clamp_lvl(input logic signed [31:0] v);
      logic [15:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 32'sd32768) begin
         r = lbsph_pkg::LEVEL_ONE;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign q_idx    = BAND_AW'(q_data.band);
   assign op_idx   = BAND_AW'(op_ff.band);
   assign in_range = {4'b0, op_ff.band} < 9'(NUM_BANDS);
   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign out_free = !out_valid_ff || out_pop;

   always_comb begin
      slot_left  = slot_valid_ff ? $signed(slot_ff[63:32]) : 32'sd0;
      slot_right = slot_valid_ff ? $signed(slot_ff[31:0]) : 32'sd0;
      slot_cur   = ch_ff ? slot_right : slot_left;

      rm   = ch_ff ? op_ff.max_right : op_ff.max_left;
      m_in = (rm > cfg.noise_floor) ? rm - cfg.noise_floor : 16'd0;

      lin_prod = m_ff * cfg.linear_gain;

      e_in = '0;
      for (int b = 0; b < 16; b++) begin
         if (m_ff[b]) begin
            e_in = 4'(b);
         end
      end
      x_in = m_ff << (4'd15 - e_in);

      idx_prod = IDX_PW'(x_ff[14:0]) * IDX_PW'(LOG_TABLE_DEPTH);

      lneg = {5'd16 - {1'b0, e_ff}, 16'd0} - {5'd0, tab_ff};

      db_sum = prod_ff + 40'hFF_FFFF;
      db_q   = 16'(db_sum >> 24);
      db     = (m_ff == '0) ? lbsph_pkg::DB_ZERO_MAG : -$signed({2'b00, db_q});
      diff   = 19'(db) - 19'(cfg.db_floor);
      range  = 17'(cfg.db_ceiling) - 17'(cfg.db_floor);
      diff_mag  = diff[18] ? 19'(-diff) : 19'(diff);
      range_mag = range[16] ? 17'(-range) : 17'(range);

      rd_divide = cfg.aggregate_mode && (fc_ff != '0) && !slot_cur[31];

      div_start = ((state_ff == S_DB) && (range != '0)) ||
                  ((state_ff == S_RDDIV) && rd_divide);
      if (state_ff == S_DB) begin
         div_num = lbsph_pkg::DIV_NUM_W'({diff_mag[15:0], 15'd0});
         div_den = range_mag[15:0];
      end else begin
         div_num = lbsph_pkg::DIV_NUM_W'(slot_cur[30:0]);
         div_den = fc_ff;
      end

      merge_left  = merge_val(slot_left, lvl_ff[0], fc_ff == '0, cfg.aggregate_mode);
      merge_right = merge_val(slot_right, lvl_ff[1], fc_ff == '0, cfg.aggregate_mode);
   end

   lbsph_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && !q_empty) begin
         slot_ff       <= store_mem[q_idx];
         slot_valid_ff <= valid_ff[q_idx];
      end
      if (state_ff == S_MERGE) begin
         store_mem[op_idx] <= {merge_left, merge_right};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fc_ff        <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
         ch_ff        <= 1'b0;
      end else begin
         if (out_valid_ff && out_pop && state_ff != S_OUT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  op_ff    <= q_data;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               ch_ff <= 1'b0;
               if (op_ff.kind == lbsph_pkg::CMD_READ) begin
                  if (in_range) begin
                     state_ff <= S_RDDIV;
                  end else begin
                     pend_ff  <= '0;
                     state_ff <= S_OUT;
                  end
               end else if (op_ff.merge && in_range) begin
                  state_ff <= S_SUB;
               end else begin
                  state_ff <= S_FRAME;
               end
            end
            S_SUB: begin
               m_ff     <= m_in;
               state_ff <= cfg.scale_mode ? S_NORM : S_LINMUL;
            end
            S_LINMUL: begin
               lvl_ff[ch_ff] <= $signed({9'd0, lin_prod[31:9]});
               state_ff      <= S_CHAN;
            end
            S_NORM: begin
               e_ff     <= e_in;
               x_ff     <= x_in;
               state_ff <= S_IDX;
            end
            S_IDX: begin
               idx_ff   <= TAB_AW'(idx_prod >> 15);
               state_ff <= S_TAB;
            end
            S_TAB: begin
               tab_ff   <= log_rom[idx_ff];
               state_ff <= S_LOGMUL;
            end
            S_LOGMUL: begin
               prod_ff  <= 40'(lneg) * 40'(lbsph_pkg::DB_K);
               state_ff <= S_DB;
            end
            S_DB: begin
               neg_ff <= diff[18] ^ range[16];
               if (range == '0) begin
                  lvl_ff[ch_ff] <= diff[18] ? 32'sd0 : 32'sd32768;
                  state_ff      <= S_CHAN;
               end else begin
                  state_ff <= S_DIVWAIT;
               end
            end
            S_DIVWAIT: begin
               if (div_done) begin
                  lvl_ff[ch_ff] <= neg_ff ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
                  state_ff      <= S_CHAN;
               end
            end
            S_CHAN: begin
               if (!ch_ff) begin
                  ch_ff    <= 1'b1;
                  state_ff <= S_SUB;
               end else begin
                  state_ff <= S_MERGE;
               end
            end
            S_MERGE: begin
               valid_ff[op_idx] <= 1'b1;
               state_ff         <= S_FRAME;
            end
            S_FRAME: begin
               if (op_ff.frame_end && fc_ff != lbsph_pkg::FRAME_COUNT_MAX) begin
                  fc_ff <= fc_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_RDDIV: begin
               if (rd_divide) begin
                  state_ff <= S_RDWAIT;
               end else begin
                  lvl_ff[ch_ff] <= slot_cur;
                  state_ff      <= S_RDNEXT;
               end
            end
            S_RDWAIT: begin
               if (div_done) begin
                  lvl_ff[ch_ff] <= $signed(div_quo[31:0]);
                  state_ff      <= S_RDNEXT;
               end
            end
            S_RDNEXT: begin
               if (!ch_ff) begin
                  ch_ff    <= 1'b1;
                  state_ff <= S_RDDIV;
               end else begin
                  pend_ff.level_left  <= (fc_ff != '0) ? clamp_lvl(lvl_ff[0]) : 16'd0;
                  pend_ff.level_right <= (fc_ff != '0) ? clamp_lvl(lvl_ff[1]) : 16'd0;
                  pend_ff.have_data   <= fc_ff != '0;
                  valid_ff[op_idx]    <= 1'b0;
                  if (op_ff.band == 5'(LAST_BAND)) begin
                     fc_ff <= '0;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  out_ff       <= pend_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (out_pop) begin
                  out_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (cfg_clear) begin
            fc_ff    <= '0;
            valid_ff <= '0;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("Divider started while still busy.");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.level_left <= lbsph_pkg::LEVEL_ONE &&
                        out_ff.level_right <= lbsph_pkg::LEVEL_ONE))
      else $error("Result level exceeds one.");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.have_data) |->
      (out_ff.level_left == 16'd0 && out_ff.level_right == 16'd0))
      else $error("Nonzero level without data.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_valid_ff && !out_pop) |=> (state_ff == S_OUT))
      else $error("Result register overwritten before it was taken.");

endmodule

// ----- sv/log_band_spectrum_peak_hold.sv -----
// Bins that do not end a band or a frame are taken one per cycle while the op queue has room.
// A band end in decibel mode waits on the back end's divider unless the dB range is zero;
// the back end shares that one divider with aggregate-mode reads, which divide by the frame count.
// Synchronous reset empties the op queue and result register, clears the running maxima,
// frame count and band valid bits and loads the register defaults; writing scale_mode
// clears the band valid bits and frame count.
module log_band_spectrum_peak_hold #(
   parameter int NUM_BANDS       = lbsph_pkg::NUM_BANDS_DEF,
   parameter int LOG_TABLE_DEPTH = lbsph_pkg::LOG_TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  lbsph_pkg::req_type                  req_data,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output lbsph_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write,
   input  logic [lbsph_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lbsph_pkg::CSR_DATA_W-1:0]    csr_data
);

   lbsph_pkg::cfg_type cfg_ff;
   logic               cfg_clear;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   lbsph_pkg::op_type  q_in_data;
   lbsph_pkg::op_type  q_out_data;
   logic               out_valid;

   assign cfg_clear = csr_write && (csr_index == lbsph_pkg::CSR_SCALE_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_mode     <= 1'b0;
         cfg_ff.aggregate_mode <= 1'b0;
         cfg_ff.noise_floor    <= 16'd0;
         cfg_ff.linear_gain    <= 16'd256;
         cfg_ff.db_floor       <= -16'sd20480;
         cfg_ff.db_ceiling     <= 16'sd0;
      end else if (csr_write) begin
         case (csr_index)
            lbsph_pkg::CSR_SCALE_MODE:     cfg_ff.scale_mode     <= csr_data[0];
            lbsph_pkg::CSR_AGGREGATE_MODE: cfg_ff.aggregate_mode <= csr_data[0];
            lbsph_pkg::CSR_NOISE_FLOOR:    cfg_ff.noise_floor    <= csr_data;
            lbsph_pkg::CSR_LINEAR_GAIN:    cfg_ff.linear_gain    <= csr_data;
            lbsph_pkg::CSR_DB_FLOOR:       cfg_ff.db_floor       <= $signed(csr_data);
            lbsph_pkg::CSR_DB_CEILING:     cfg_ff.db_ceiling     <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   lbsph_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (q_in_data),
      .q_full   (q_full)
   );

   lbsph_fifo u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out_data)
   );

   lbsph_back #(
      .NUM_BANDS       (NUM_BANDS),
      .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_clear (cfg_clear),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_out_data),
      .out_valid (out_valid),
      .out_data  (rsp_data),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty = !out_valid;

endmodule

// ----- tb/lbsph_checker.sv -----
module lbsph_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic                              req_full,
   input  lbsph_pkg::req_type                req_data,
   input  logic                              rsp_empty,
   input  logic                              rsp_pop,
   input  lbsph_pkg::rsp_type                rsp_data,
   input  logic                              csr_write,
   input  logic [lbsph_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbsph_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                failures,
   output int                                pending
);

   localparam int BANDS = lbsph_pkg::NUM_BANDS_DEF;
   localparam int DEPTH = lbsph_pkg::LOG_TABLE_DEPTH_DEF;

   typedef longint unsigned u64_type;

   logic [15:0] log2_frac [DEPTH];
   logic        scale_db;
   logic        avg_mode;
   logic [15:0] floor_mag;
   logic [15:0] gain;
   longint      db_lo;
   longint      db_hi;
   logic [15:0] peak_l;
   logic [15:0] peak_r;
   int          store_l [BANDS];
   int          store_r [BANDS];
   int unsigned frames;
   lbsph_pkg::rsp_type levels_due [$];

   function automatic logic [15:0] frac_log2(int i);
      u64_type v;
      logic [15:0] r;
      v = (u64_type'(DEPTH + i) << 30) / DEPTH;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         v = (v * v) >> 30;
         r = {r[14:0], 1'b0};
         if (v >= 64'h8000_0000) begin
            r[0] = 1'b1;
            v = v >> 1;
         end
      end
      return r;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint to_db(logic [15:0] m);
      int e;
      u64_type x, idx, lneg, q;
      if (m == 0) return -51200;
      e = 15;
      while (e > 0 && !m[e]) e--;
      x = (u64_type'(m) << (15 - e)) & 64'hFFFF;
      idx = ((x - 32768) * DEPTH) >> 15;
      lneg = (u64_type'(16 - e) << 16) - log2_frac[idx];
      q = (lneg * 394566 + ((64'd1 << 24) - 1)) >> 24;
      return -longint'(q);
   endfunction

   function automatic longint band_level(logic [15:0] peak);
      logic [15:0] m;
      longint db, span;
      m = (peak > floor_mag) ? peak - floor_mag : 16'd0;
      if (!scale_db) return longint'((u64_type'(m) * gain) >> 9);
      db = to_db(m);
      span = db_hi - db_lo;
      if (span == 0) return (db >= db_lo) ? 32768 : 0;
      return clamp32(((db - db_lo) * 32768) / span);
   endfunction

   function automatic int fold(int slot, longint lv);
      lv = clamp32(lv);
      if (frames == 0) return int'(lv);
      if (avg_mode) return int'(clamp32(longint'(slot) + lv));
      return (lv > slot) ? int'(lv) : slot;
   endfunction

   function automatic logic [15:0] read_out(int v);
      longint x;
      x = v;
      if (avg_mode) x = x / longint'(frames);
      if (x < 0) return 16'd0;
      if (x > 32768) return 16'd32768;
      return x[15:0];
   endfunction

   task automatic clear_bands();
      for (int d = 0; d < BANDS; d++) begin
         store_l[d] = 0;
         store_r[d] = 0;
      end
      frames = 0;
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) log2_frac[i] = frac_log2(i);
   end

   always @(posedge clock) begin
      lbsph_pkg::rsp_type got, want;
      if (reset) begin
         scale_db = 1'b0;
         avg_mode = 1'b0;
         floor_mag = 16'd0;
         gain = 16'd256;
         db_lo = -20480;
         db_hi = 0;
         peak_l = 16'd0;
         peak_r = 16'd0;
         clear_bands();
         levels_due.delete();
         failures = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               lbsph_pkg::CSR_SCALE_MODE: begin
                  scale_db = csr_data[0];
                  clear_bands();
               end
               lbsph_pkg::CSR_AGGREGATE_MODE: avg_mode = csr_data[0];
               lbsph_pkg::CSR_NOISE_FLOOR:    floor_mag = csr_data;
               lbsph_pkg::CSR_LINEAR_GAIN:    gain = csr_data;
               lbsph_pkg::CSR_DB_FLOOR:       db_lo = longint'($signed(csr_data));
               lbsph_pkg::CSR_DB_CEILING:     db_hi = longint'($signed(csr_data));
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            got = rsp_data;
            if (levels_due.size() == 0) begin
               $error("unexpected result %h", got);
               failures++;
            end else begin
               want = levels_due.pop_front();
               if (got.level_left !== want.level_left) begin
                  $error("level_left expected %0d got %0d", want.level_left, got.level_left);
                  failures++;
               end
               if (got.level_right !== want.level_right) begin
                  $error("level_right expected %0d got %0d", want.level_right,
                         got.level_right);
                  failures++;
               end
               if (got.have_data !== want.have_data) begin
                  $error("have_data expected %0d got %0d", want.have_data, got.have_data);
                  failures++;
               end
            end
         end
         if (req_push && !req_full) begin
            if (req_data.cmd == lbsph_pkg::CMD_BIN) begin
               if (req_data.mag_left > peak_l) peak_l = req_data.mag_left;
               if (req_data.mag_right > peak_r) peak_r = req_data.mag_right;
               if (req_data.last_of_band) begin
                  store_l[req_data.band] = fold(store_l[req_data.band], band_level(peak_l));
                  store_r[req_data.band] = fold(store_r[req_data.band], band_level(peak_r));
                  peak_l = 16'd0;
                  peak_r = 16'd0;
               end
               if (req_data.last_of_frame && frames < 65535) frames++;
            end else begin
               want = '0;
               if (frames != 0) begin
                  want.level_left = read_out(store_l[req_data.band]);
                  want.level_right = read_out(store_r[req_data.band]);
                  want.have_data = 1'b1;
               end
               levels_due.push_back(want);
               store_l[req_data.band] = 0;
               store_r[req_data.band] = 0;
               if (req_data.band == BANDS - 1) frames = 0;
            end
         end
      end
      pending = levels_due.size();
   end

endmodule

// ----- tb/log_band_spectrum_peak_hold_test.sv -----
module log_band_spectrum_peak_hold_test;

   logic                              clock;
   logic                              reset;
   logic                              req_push;
   lbsph_pkg::req_type                req_data;
   logic                              req_full;
   logic                              rsp_empty;
   logic                              rsp_pop;
   lbsph_pkg::rsp_type                rsp_data;
   logic                              csr_write;
   logic [lbsph_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lbsph_pkg::CSR_DATA_W-1:0]  csr_data;
   int                                failures;
   int                                pending;
   int                                tx_idle;
   int                                rx_idle;

   log_band_spectrum_peak_hold uut (.*);

   lbsph_checker check (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= rx_idle);
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [15:0] pick_mag();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(65535) >> $urandom_range(15));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   task automatic send(lbsph_pkg::cmd_type cmd, int band, logic [15:0] ml, logic [15:0] mr,
                       logic lob, logic lof);
      lbsph_pkg::req_type it;
      it.cmd = cmd;
      it.band = 5'(band);
      it.mag_left = ml;
      it.mag_right = mr;
      it.last_of_band = lob;
      it.last_of_frame = lof;
      if ($urandom_range(99) < tx_idle) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic csr_put(lbsph_pkg::csr_index_type idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic noise(int n);
      repeat (n) begin
         if ($urandom_range(3) == 0)
            send(lbsph_pkg::CMD_READ, $urandom_range(31), 16'($urandom), 16'($urandom),
                 1'($urandom), 1'($urandom));
         else
            send(lbsph_pkg::CMD_BIN, $urandom_range(31), pick_mag(), pick_mag(),
                 1'($urandom), 1'($urandom_range(7) == 0));
      end
   endtask

   task automatic segment(logic db, logic avg, logic [15:0] nf, logic [15:0] g,
                          logic [15:0] lo, logic [15:0] hi);
      int nbins;
      settle();
      csr_put(lbsph_pkg::CSR_SCALE_MODE, {15'd0, db});
      csr_put(lbsph_pkg::CSR_AGGREGATE_MODE, {15'd0, avg});
      csr_put(lbsph_pkg::CSR_NOISE_FLOOR, nf);
      csr_put(lbsph_pkg::CSR_LINEAR_GAIN, g);
      csr_put(lbsph_pkg::CSR_DB_FLOOR, lo);
      csr_put(lbsph_pkg::CSR_DB_CEILING, hi);
      repeat ($urandom_range(1, 2)) begin
         for (int b = 0; b < 32; b++) begin
            nbins = $urandom_range(1, 2);
            for (int k = 0; k < nbins; k++)
               send(lbsph_pkg::CMD_BIN, b, pick_mag(), pick_mag(), k == nbins - 1,
                    b == 31 && k == nbins - 1);
            if ($urandom_range(19) == 0)
               send(lbsph_pkg::CMD_READ, $urandom_range(31), 0, 0, 0, 0);
         end
      end
      for (int b = 0; b < 32; b++) send(lbsph_pkg::CMD_READ, b, 0, 0, 0, 0);
      noise(12);
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_pop = 1'b0;
      tx_idle = 21;
      rx_idle = 81;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(lbsph_pkg::CMD_READ, 3, 0, 0, 0, 0);
      send(lbsph_pkg::CMD_BIN, 0, 16'hFFFF, 16'h0000, 1, 0);
      send(lbsph_pkg::CMD_BIN, 1, 16'h0001, 16'h8000, 0, 0);
      send(lbsph_pkg::CMD_BIN, 1, 16'h0000, 16'hFFFF, 1, 1);
      send(lbsph_pkg::CMD_READ, 0, 0, 0, 0, 0);
      send(lbsph_pkg::CMD_READ, 1, 0, 0, 0, 0);
      send(lbsph_pkg::CMD_READ, 31, 0, 0, 0, 0);
      send(lbsph_pkg::CMD_READ, 1, 0, 0, 0, 0);
      send(lbsph_pkg::CMD_BIN, 31, 16'h0000, 16'h0000, 1, 1);
      send(lbsph_pkg::CMD_BIN, 2, 16'h1234, 16'hFFFF, 1, 1);
      send(lbsph_pkg::CMD_READ, 2, 0, 0, 0, 0);
      send(lbsph_pkg::CMD_READ, 31, 0, 0, 0, 0);

      segment(0, 0, 16'd0, 16'd256, 16'hB000, 16'h0000);
      segment(1, 1, 16'd0, 16'hFFFF, 16'h8000, 16'h0000);
      segment(1, 0, 16'($urandom_range(4000)), 16'd0, 16'hEC78, 16'hEC78);
      tx_idle = 81;
      rx_idle = 21;
      segment(0, 1, 16'($urandom_range(255)), 16'hFFFF, 16'h0000, 16'h8000);
      segment(1, 1, 16'($urandom_range(2000)), 16'($urandom), 16'h0000, 16'hD120);
      segment(0, 0, 16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom));
      tx_idle = 0;
      rx_idle = 0;
      segment(1, 0, 16'($urandom_range(100)), 16'($urandom), 16'hC000 | 16'($urandom),
              16'hF000 | 16'($urandom));
      segment(0, 1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));

      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
